/* src/first_fit_chunk_allocator_top_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the first-fit chunk allocator
// Shared property forms used by the port checker.
// -----------------------------------------------------------------------------
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle during reset.
`define FFCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk_i and idle during reset.
`define FFCA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* src/ffca_pkg.sv */
// -----------------------------------------------------------------------------
// ffca_pkg
// Constants, types and control structs shared by the allocator modules.
// -----------------------------------------------------------------------------
package ffca_pkg;

  localparam int ARENA_CAPACITY     = 16384;
  localparam int GRANULE            = 4096;
  localparam int CHUNK_HEADER_BYTES = 8;
  localparam int ARENA_HEADER_BYTES = 40;

  localparam int AW        = $clog2(ARENA_CAPACITY);
  localparam int LW        = $clog2(ARENA_CAPACITY + 1);
  localparam int SW        = LW + 1;
  localparam int GSH       = $clog2(GRANULE);
  localparam int CFGW      = 12;
  localparam int FIRST_MAP = (GRANULE > ARENA_CAPACITY) ? ARENA_CAPACITY : GRANULE;
  localparam int ROOM      = FIRST_MAP - ARENA_HEADER_BYTES - CHUNK_HEADER_BYTES;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_FREE    = 2'd1;
  localparam logic [1:0] MODE_REALLOC = 2'd2;

  typedef struct packed {
    logic [LW-1:0] used;
    logic [LW-1:0] free_bytes;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DISPATCH, ST_A_LOAD, ST_A_EVAL, ST_A_SPLIT,
    ST_F_READ, ST_F_LOAD, ST_C_START, ST_C_LOAD, ST_C_EVAL, ST_C_NEXT,
    ST_R_LOAD, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {RD_BASE, RD_CHUNK, RD_END} rd_sel_e;

  typedef enum logic [2:0] {
    WR_INIT, WR_GROW, WR_TRIM, WR_SPLIT, WR_FREE, WR_MERGE, WR_RESIZE
  } wr_sel_e;

  typedef enum logic [1:0] {T_HOLD, T_BASE, T_END} t_sel_e;

  typedef enum logic [1:0] {UF_HOLD, UF_MEM, UF_MERGE} uf_sel_e;

  typedef struct packed {
    logic    capture;
    logic    clr_result;
    logic    set_fail;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    t_sel_e  t_sel;
    uf_sel_e uf_sel;
    logic    grow;
    logic    res_split;
    logic    res_handle;
    logic    copy_set;
    logic    old_used_ld;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       handle_small;
    logic       size_zero;
    logic       realloc_move;
    logic       last;
    logic       fits;
    logic       no_room;
    logic       next_free;
    logic       resize_fits;
    logic       out_free;
  } sts_t;

endpackage

/* src/first_fit_chunk_allocator_top.sv */
// -----------------------------------------------------------------------------
// first_fit_chunk_allocator_top
// First-fit chunk allocator with free-chunk coalescing over a byte arena.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_ready_o  mode_i, handle_i, size_i
// result    out        out_valid_o/out_ready_i  result_handle_o, failed_o, copy_*_o
// config    in         cfg_we_i (no wait)       cfg_wdata_i (first chunk bytes)
//
// After acceptance an allocate walks the chunks from the first one and grows the
// mapping when the last chunk does not fit. A free marks the chunk free and then
// runs a coalescing pass over the chain; a reallocate resizes in place when it can,
// and a moving one runs both walks; zero size, free of none and mode 3 just finish.
// The next request is accepted in the idle cycle that follows.
// After reset the block writes the first chunk header before it takes a request.
// The result sits in an output register, so a stalled result does not hold
// off the next request; only the finishing step waits for that register.
// -----------------------------------------------------------------------------
module first_fit_chunk_allocator_top import ffca_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CFGW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      mode_i,
  input  logic [AW-1:0]   handle_i,
  input  logic [LW-1:0]   size_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [AW-1:0]   result_handle_o,
  output logic            failed_o,
  output logic            copy_needed_o,
  output logic [AW-1:0]   copy_from_o,
  output logic [AW-1:0]   copy_to_o,
  output logic [LW-1:0]   copy_length_o
);

  // The controller and datapath talk only through these two structs.
  cmd_t cmd;
  sts_t sts;

  ffca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffca_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (mode_i),
    .handle_i        (handle_i),
    .size_i          (size_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .result_handle_o (result_handle_o),
    .failed_o        (failed_o),
    .copy_needed_o   (copy_needed_o),
    .copy_from_o     (copy_from_o),
    .copy_to_o       (copy_to_o),
    .copy_length_o   (copy_length_o)
  );

endmodule

/* src/ffca_datapath.sv */
// -----------------------------------------------------------------------------
// ffca_datapath
// Header memory, chain walk registers, arithmetic and the result register.
// -----------------------------------------------------------------------------
module ffca_datapath import ffca_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CFGW-1:0] cfg_wdata_i,
  input  logic [1:0]      mode_i,
  input  logic [AW-1:0]   handle_i,
  input  logic [LW-1:0]   size_i,
  input  logic            out_ready_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  output logic            out_valid_o,
  output logic [AW-1:0]   result_handle_o,
  output logic            failed_o,
  output logic            copy_needed_o,
  output logic [AW-1:0]   copy_from_o,
  output logic [AW-1:0]   copy_to_o,
  output logic [LW-1:0]   copy_length_o
);

  hdr_t          hdr_mem_q [ARENA_CAPACITY];
  hdr_t          rd_q;
  logic [1:0]    mode_q;
  logic [AW-1:0] handle_q, t_q, res_q, cfrom_q, cto_q;
  logic [LW-1:0] size_q, u_q, f_q, mapped_q, old_used_q, clen_q;
  logic          fail_q, copy_q;
  logic          out_valid_q, ofail_q, ocopy_q;
  logic [AW-1:0] ohandle_q, ofrom_q, oto_q;
  logic [LW-1:0] olen_q;

  logic [SW-1:0] sz, end_w, need, deficit, grow, room_left, split_at, rd_sum, merged;
  logic [AW-1:0] chunk, split_handle, rd_addr, wr_addr;
  logic [LW-1:0] cfg_used, init_used;
  hdr_t          wr_data;
  logic          wr_en;

  assign sz           = SW'(CHUNK_HEADER_BYTES) + SW'(u_q) + SW'(f_q);
  assign end_w        = SW'(t_q) + sz;
  assign need         = SW'(size_q) + SW'(CHUNK_HEADER_BYTES);
  assign deficit      = need - SW'(f_q);
  assign grow         = ((deficit + SW'(GRANULE - 1)) >> GSH) << GSH;
  assign room_left    = SW'(ARENA_CAPACITY) - SW'(mapped_q);
  assign split_at     = SW'(t_q) + SW'(CHUNK_HEADER_BYTES) + SW'(u_q);
  assign split_handle = split_at[AW-1:0] + AW'(CHUNK_HEADER_BYTES);
  assign chunk        = handle_q - AW'(CHUNK_HEADER_BYTES);
  assign rd_sum       = SW'(rd_q.used) + SW'(rd_q.free_bytes);
  assign merged       = SW'(f_q) + SW'(CHUNK_HEADER_BYTES) + SW'(rd_q.free_bytes);
  assign cfg_used     = (LW'(cfg_wdata_i) > LW'(ROOM)) ? LW'(ROOM) : LW'(cfg_wdata_i);
  assign init_used    = '0;

  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.handle_small = handle_q < AW'(CHUNK_HEADER_BYTES);
    sts_o.size_zero    = (size_q == '0);
    sts_o.realloc_move = (mode_q == MODE_REALLOC) && !sts_o.handle_small && !sts_o.size_zero;
    sts_o.last         = end_w >= SW'(mapped_q);
    sts_o.fits         = SW'(f_q) >= need;
    sts_o.no_room      = grow > room_left;
    sts_o.next_free    = (rd_q.used == '0);
    sts_o.resize_fits  = rd_sum >= SW'(size_q);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_BASE:  rd_addr = AW'(ARENA_HEADER_BYTES);
      RD_CHUNK: rd_addr = chunk;
      RD_END:   rd_addr = end_w[AW-1:0];
      default:  rd_addr = AW'(ARENA_HEADER_BYTES);
    endcase
  end

  // A configuration write lays the arena out afresh and wins over the controller.
  always_comb begin
    wr_en   = cmd_i.wr_en;
    wr_addr = t_q;
    wr_data = '{used: u_q, free_bytes: f_q};
    unique case (cmd_i.wr_sel)
      WR_INIT: begin
        wr_addr = AW'(ARENA_HEADER_BYTES);
        wr_data = '{used: init_used, free_bytes: LW'(ROOM) - init_used};
      end
      WR_GROW:   wr_data = '{used: u_q, free_bytes: f_q + grow[LW-1:0]};
      WR_TRIM:   wr_data = '{used: u_q, free_bytes: '0};
      WR_SPLIT: begin
        wr_addr = split_at[AW-1:0];
        wr_data = '{used: size_q, free_bytes: f_q - need[LW-1:0]};
      end
      WR_FREE: begin
        wr_addr = chunk;
        wr_data = '{used: '0, free_bytes: rd_sum[LW-1:0]};
      end
      WR_MERGE:  wr_data = '{used: u_q, free_bytes: merged[LW-1:0]};
      WR_RESIZE: begin
        wr_addr = chunk;
        wr_data = '{used: size_q, free_bytes: rd_sum[LW-1:0] - size_q};
      end
      default: wr_data = '{used: u_q, free_bytes: f_q};
    endcase
    if (cfg_we_i) begin
      wr_en   = 1'b1;
      wr_addr = AW'(ARENA_HEADER_BYTES);
      wr_data = '{used: cfg_used, free_bytes: LW'(ROOM) - cfg_used};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= hdr_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= mode_i;
      handle_q <= handle_i;
      size_q   <= size_i;
    end
    unique case (cmd_i.t_sel)
      T_BASE:  t_q <= AW'(ARENA_HEADER_BYTES);
      T_END:   t_q <= end_w[AW-1:0];
      default: t_q <= t_q;
    endcase
    if (cmd_i.grow) begin
      f_q <= f_q + grow[LW-1:0];
    end else begin
      unique case (cmd_i.uf_sel)
        UF_MEM: begin
          u_q <= rd_q.used;
          f_q <= rd_q.free_bytes;
        end
        UF_MERGE: f_q <= merged[LW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.old_used_ld) begin
      old_used_q <= rd_q.used;
    end
    if (cmd_i.clr_result) begin
      res_q   <= '0;
      fail_q  <= 1'b0;
      copy_q  <= 1'b0;
      cfrom_q <= '0;
      cto_q   <= '0;
      clen_q  <= '0;
    end
    if (cmd_i.set_fail) begin
      res_q  <= '0;
      fail_q <= 1'b1;
    end
    if (cmd_i.res_split) begin
      res_q <= split_handle;
    end
    if (cmd_i.res_handle) begin
      res_q <= handle_q;
    end
    if (cmd_i.copy_set) begin
      copy_q  <= 1'b1;
      cfrom_q <= handle_q;
      cto_q   <= split_handle;
      clen_q  <= (size_q < old_used_q) ? size_q : old_used_q;
    end
    if (cmd_i.out_load) begin
      ohandle_q <= res_q;
      ofail_q   <= fail_q;
      ocopy_q   <= copy_q;
      ofrom_q   <= cfrom_q;
      oto_q     <= cto_q;
      olen_q    <= clen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q    <= LW'(FIRST_MAP);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mapped_q <= LW'(FIRST_MAP);
      end else if (cmd_i.grow) begin
        mapped_q <= mapped_q + grow[LW-1:0];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = ohandle_q;
  assign failed_o        = ofail_q;
  assign copy_needed_o   = ocopy_q;
  assign copy_from_o     = ofrom_q;
  assign copy_to_o       = oto_q;
  assign copy_length_o   = olen_q;

endmodule

/* src/ffca_ctrl.sv */
// -----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer for allocate, free, coalesce and reallocate walks.
// -----------------------------------------------------------------------------
module ffca_ctrl import ffca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_INIT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_INIT;
        state_d      = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.clr_result = 1'b1;
        priority if (sts_i.mode == MODE_FREE) begin
          if (sts_i.handle_small) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_CHUNK;
            state_d      = ST_F_LOAD;
          end
        end else if (sts_i.mode == MODE_REALLOC && sts_i.realloc_move) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_CHUNK;
          state_d      = ST_R_LOAD;
        end else if (sts_i.mode == MODE_ALLOC || sts_i.mode == MODE_REALLOC) begin
          if (sts_i.size_zero) begin
            cmd_o.set_fail = 1'b1;
            state_d        = ST_FINISH;
          end else begin
            cmd_o.t_sel  = T_BASE;
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_BASE;
            state_d      = ST_A_LOAD;
          end
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_A_LOAD: begin
        cmd_o.uf_sel = UF_MEM;
        state_d      = ST_A_EVAL;
      end
      ST_A_EVAL: begin
        priority if (sts_i.last && !sts_i.fits) begin
          if (sts_i.no_room) begin
            cmd_o.set_fail = 1'b1;
            state_d        = ST_FINISH;
          end else begin
            cmd_o.grow   = 1'b1;
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_GROW;
          end
        end else if (sts_i.fits) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_TRIM;
          state_d      = ST_A_SPLIT;
        end else begin
          cmd_o.t_sel  = T_END;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_END;
          state_d      = ST_A_LOAD;
        end
      end
      ST_A_SPLIT: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_SPLIT;
        cmd_o.res_split = 1'b1;
        if (sts_i.realloc_move) begin
          cmd_o.copy_set = 1'b1;
          state_d        = ST_F_READ;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_F_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_CHUNK;
        state_d      = ST_F_LOAD;
      end
      ST_F_LOAD: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_FREE;
        state_d      = ST_C_START;
      end
      ST_C_START: begin
        cmd_o.t_sel  = T_BASE;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_BASE;
        state_d      = ST_C_LOAD;
      end
      ST_C_LOAD: begin
        cmd_o.uf_sel = UF_MEM;
        state_d      = ST_C_EVAL;
      end
      ST_C_EVAL: begin
        if (sts_i.last) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_END;
          state_d      = ST_C_NEXT;
        end
      end
      ST_C_NEXT: begin
        if (sts_i.next_free) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_MERGE;
          cmd_o.uf_sel = UF_MERGE;
        end else begin
          cmd_o.t_sel  = T_END;
          cmd_o.uf_sel = UF_MEM;
        end
        state_d = ST_C_EVAL;
      end
      ST_R_LOAD: begin
        cmd_o.old_used_ld = 1'b1;
        if (sts_i.resize_fits) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel     = WR_RESIZE;
          cmd_o.res_handle = 1'b1;
          state_d          = ST_FINISH;
        end else begin
          cmd_o.t_sel  = T_BASE;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_BASE;
          state_d      = ST_A_LOAD;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* src/ffca_checker.sv */
// -----------------------------------------------------------------------------
// ffca_checker
// Port-level checks on the allocator result channel.
// -----------------------------------------------------------------------------
`include "first_fit_chunk_allocator_top_defines.svh"

module ffca_checker import ffca_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [AW-1:0] result_handle_o,
  input logic          failed_o,
  input logic          copy_needed_o,
  input logic [AW-1:0] copy_from_o,
  input logic [AW-1:0] copy_to_o,
  input logic [LW-1:0] copy_length_o
);

  `FFCA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_handle_o))
  `FFCA_ASSERT_IMP(a_fail_no_handle, out_valid_o && failed_o, result_handle_o == '0 && !copy_needed_o)
  `FFCA_ASSERT_IMP(a_copy_zero, out_valid_o && !copy_needed_o, copy_from_o == '0 && copy_to_o == '0 && copy_length_o == '0)
  `FFCA_ASSERT_IMP(a_copy_target, out_valid_o && copy_needed_o, copy_to_o == result_handle_o && copy_from_o != '0)

endmodule

bind first_fit_chunk_allocator_top ffca_checker u_ffca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .result_handle_o (result_handle_o),
  .failed_o        (failed_o),
  .copy_needed_o   (copy_needed_o),
  .copy_from_o     (copy_from_o),
  .copy_to_o       (copy_to_o),
  .copy_length_o   (copy_length_o)
);
